[rtl/ftc_pkg.sv]
// Shared types and constants for the frame number to timecode converter.
package ftc_pkg;

  // Field widths of the result beat
  localparam int HOURS_BITS   = 21;
  localparam int MINUTES_BITS = 6;
  localparam int SECONDS_BITS = 6;
  localparam int FRAMES_BITS  = 7;
  localparam int FPS_BITS     = 7;

  // Configuration register indexes
  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DROP_FRAME        = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAMES_PER_SECOND = 2'd1;
  localparam logic [FPS_BITS-1:0]       FPS_RESET             = 7'd30;

  // 29.97 drop-frame geometry
  localparam int DF_FRAMES_PER_10MIN  = 17982;
  localparam int DF_FRAMES_PER_MIN    = 1798;
  localparam int DF_DROPS_PER_10MIN   = 18;
  localparam int DF_DROPS_PER_MIN     = 2;
  localparam int DF_MINUTES_PER_BLOCK = 10;
  localparam int DF_LABELS            = 30;
  localparam int DF_REM_BITS          = 15;  // holds a remainder below 17982

  // Time split
  localparam int SECONDS_PER_HOUR   = 3600;
  localparam int SECONDS_PER_MINUTE = 60;
  localparam int HOUR_REM_BITS      = 12;    // holds a remainder below 3600

  // Rate settings that travel with each beat
  typedef struct packed {
    logic                drop;
    logic [FPS_BITS-1:0] fps;
  } rate_t;

endpackage

[rtl/ftc_divider.sv]
// Pipelined restoring divider, STEP_BITS quotient bits per stage, with sideband.
module ftc_divider #(
  parameter int DIVIDEND_BITS = 32,
  parameter int DIVISOR_BITS  = 8,
  parameter int STEP_BITS     = 4,
  parameter int SIDE_BITS     = 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [DIVIDEND_BITS-1:0] in_dividend,
  input  logic [DIVISOR_BITS-1:0]  in_divisor,
  input  logic [SIDE_BITS-1:0]     in_side,
  output logic                     out_valid,
  output logic [DIVIDEND_BITS-1:0] out_quotient,
  output logic [DIVISOR_BITS-1:0]  out_remainder,
  output logic [SIDE_BITS-1:0]     out_side
);

  localparam int STAGES   = (DIVIDEND_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int PAD_BITS = STAGES * STEP_BITS;

  // Dividend bits shift out at the top while quotient bits shift in below
  logic                    vld [STAGES];
  logic [PAD_BITS-1:0]     acc [STAGES];
  logic [DIVISOR_BITS-1:0] rem [STAGES];
  logic [DIVISOR_BITS-1:0] dsr [STAGES];
  logic [SIDE_BITS-1:0]    side [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic                    v_in;
    logic [PAD_BITS-1:0]     a_in;
    logic [DIVISOR_BITS-1:0] r_in;
    logic [DIVISOR_BITS-1:0] d_in;
    logic [SIDE_BITS-1:0]    s_in;
    logic [PAD_BITS-1:0]     a_next;
    logic [DIVISOR_BITS-1:0] r_next;
    logic [DIVISOR_BITS:0]   trial;

    if (s == 0) begin : g_first
      assign v_in = in_valid;
      assign a_in = PAD_BITS'(in_dividend);
      assign r_in = '0;
      assign d_in = in_divisor;
      assign s_in = in_side;
    end else begin : g_rest
      assign v_in = vld[s-1];
      assign a_in = acc[s-1];
      assign r_in = rem[s-1];
      assign d_in = dsr[s-1];
      assign s_in = side[s-1];
    end

    always_comb begin
      a_next = a_in;
      r_next = r_in;
      trial  = '0;
      for (int k = 0; k < STEP_BITS; k++) begin
        trial  = {r_next, a_next[PAD_BITS-1]};
        a_next = {a_next[PAD_BITS-2:0], 1'b0};
        if (trial >= {1'b0, d_in}) begin
          trial     = trial - {1'b0, d_in};
          a_next[0] = 1'b1;
        end
        r_next = trial[DIVISOR_BITS-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else begin
        vld[s] <= v_in;
      end
      acc[s]  <= a_next;
      rem[s]  <= r_next;
      dsr[s]  <= d_in;
      side[s] <= s_in;
    end
  end

  assign out_valid     = vld[STAGES-1];
  assign out_quotient  = acc[STAGES-1][DIVIDEND_BITS-1:0];
  assign out_remainder = rem[STAGES-1];
  assign out_side      = side[STAGES-1];

endmodule

[rtl/ftc_drop_adjust.sv]
// Two-stage drop-frame correction: add the skipped labels back to the count.
module ftc_drop_adjust #(
  parameter int COUNT_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic [COUNT_BITS-1:0]              in_count,
  input  logic [COUNT_BITS-1:0]              in_blocks,
  input  logic [ftc_pkg::DF_REM_BITS-1:0]    in_block_rem,
  input  ftc_pkg::rate_t                     in_rate,
  output logic                               out_valid,
  output logic [COUNT_BITS:0]                out_count,
  output ftc_pkg::rate_t                     out_rate
);

  localparam int MIN_MARKS = ftc_pkg::DF_MINUTES_PER_BLOCK - 1;

  logic [MIN_MARKS-1:0]        past_mark;
  logic [3:0]                  minute_next;
  logic [COUNT_BITS-1:0]       extra_next;

  logic                        v1;
  logic [COUNT_BITS-1:0]       count1;
  logic [COUNT_BITS-1:0]       extra1;
  logic [3:0]                  minute1;
  ftc_pkg::rate_t              rate1;
  logic [COUNT_BITS:0]         count_next;

  // Minute within the 10-minute block: the first minute keeps labels 0 and 1,
  // so every later minute starts two frames past a multiple of 1798.
  always_comb begin
    for (int k = 0; k < MIN_MARKS; k++) begin
      past_mark[k] = in_block_rem >= ftc_pkg::DF_REM_BITS'(
        (k + 1) * ftc_pkg::DF_FRAMES_PER_MIN + ftc_pkg::DF_DROPS_PER_MIN);
    end
    minute_next = 4'($countones(past_mark));
    extra_next  = COUNT_BITS'(in_blocks * ftc_pkg::DF_DROPS_PER_10MIN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    count1  <= in_count;
    extra1  <= extra_next;
    minute1 <= minute_next;
    rate1   <= in_rate;
  end

  always_comb begin
    if (rate1.drop) begin
      count_next = {1'b0, count1} + {1'b0, extra1}
                 + (COUNT_BITS+1)'(minute1 * ftc_pkg::DF_DROPS_PER_MIN);
    end else begin
      count_next = {1'b0, count1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v1;
    end
    out_count <= count_next;
    out_rate  <= rate1;
  end

endmodule

[rtl/frame_number_to_timecode.sv]
// Top level: frame count to SMPTE hours, minutes, seconds and frame label.
// Throughput: one beat per cycle; chained dividers retire 4 quotient bits per stage.
// Reset: rst clears every valid bit and sets drop_frame = 0, frames_per_second = 30.
// busy is high only during reset; the receiver takes each done beat as it comes.
module frame_number_to_timecode #(
  parameter int FRAME_COUNT_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Conversion request
  input  logic                                 start,
  output logic                                 busy,
  input  logic [FRAME_COUNT_BITS-1:0]          frame_number,
  // Result beat
  output logic                                 done,
  output logic [ftc_pkg::HOURS_BITS-1:0]       hours,
  output logic [ftc_pkg::MINUTES_BITS-1:0]     minutes,
  output logic [ftc_pkg::SECONDS_BITS-1:0]     seconds,
  output logic [ftc_pkg::FRAMES_BITS-1:0]      frames,
  // Register write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ftc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [ftc_pkg::FPS_BITS-1:0]         cfg_data
);

  localparam int STEP_BITS  = 4;
  localparam int W          = FRAME_COUNT_BITS;
  localparam int RATE_BITS  = $bits(ftc_pkg::rate_t);
  localparam int SIDE_C     = 1 + ftc_pkg::FRAMES_BITS;
  localparam int SIDE_D     = SIDE_C + ftc_pkg::HOURS_BITS;
  localparam int LATENCY    = (W + STEP_BITS - 1) / STEP_BITS + 2
                            + 2 * ((W + STEP_BITS) / STEP_BITS)
                            + (ftc_pkg::HOUR_REM_BITS + STEP_BITS - 1) / STEP_BITS;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic                          drop_frame;
  logic [ftc_pkg::FPS_BITS-1:0]  frames_per_second;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      drop_frame        <= 1'b0;
      frames_per_second <= ftc_pkg::FPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ftc_pkg::CFG_DROP_FRAME:        drop_frame        <= cfg_data[0];
        ftc_pkg::CFG_FRAMES_PER_SECOND: frames_per_second <= cfg_data;
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Entry: latch the rate settings with the beat so every stage sees them
  // ---------------------------------------------------------------------
  logic           in_valid;
  ftc_pkg::rate_t in_rate;

  assign busy     = rst;
  assign in_valid = start && !busy;

  always_comb begin
    in_rate.drop = drop_frame;
    // Treat a zero rate as one frame per second in non-drop mode
    if (drop_frame) begin
      in_rate.fps = ftc_pkg::FPS_BITS'(ftc_pkg::DF_LABELS);
    end else if (frames_per_second == '0) begin
      in_rate.fps = ftc_pkg::FPS_BITS'(1);
    end else begin
      in_rate.fps = frames_per_second;
    end
  end

  // ---------------------------------------------------------------------
  // Stage A: split the count into 10-minute drop-frame blocks
  // ---------------------------------------------------------------------
  logic                               a_valid;
  logic [W-1:0]                       a_blocks;
  logic [ftc_pkg::DF_REM_BITS-1:0]    a_block_rem;
  logic [W+RATE_BITS-1:0]             a_side;

  ftc_divider #(
    .DIVIDEND_BITS (W),
    .DIVISOR_BITS  (ftc_pkg::DF_REM_BITS),
    .STEP_BITS     (STEP_BITS),
    .SIDE_BITS     (W + RATE_BITS)
  ) u_div_block (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_dividend   (frame_number),
    .in_divisor    (ftc_pkg::DF_REM_BITS'(ftc_pkg::DF_FRAMES_PER_10MIN)),
    .in_side       ({frame_number, in_rate}),
    .out_valid     (a_valid),
    .out_quotient  (a_blocks),
    .out_remainder (a_block_rem),
    .out_side      (a_side)
  );

  // ---------------------------------------------------------------------
  // Stage B: in drop-frame mode put the skipped labels back, giving a count in 30-label seconds
  // ---------------------------------------------------------------------
  logic           b_valid;
  logic [W:0]     b_count;
  ftc_pkg::rate_t b_rate;

  ftc_drop_adjust #(
    .COUNT_BITS (W)
  ) u_drop_adjust (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (a_valid),
    .in_count     (a_side[W+RATE_BITS-1:RATE_BITS]),
    .in_blocks    (a_blocks),
    .in_block_rem (a_block_rem),
    .in_rate      (ftc_pkg::rate_t'(a_side[RATE_BITS-1:0])),
    .out_valid    (b_valid),
    .out_count    (b_count),
    .out_rate     (b_rate)
  );

  // ---------------------------------------------------------------------
  // Stage C: total seconds and frame label
  // ---------------------------------------------------------------------
  logic                             c_valid;
  logic [W:0]                       c_total_sec;
  logic [ftc_pkg::FRAMES_BITS-1:0]  c_frames;
  logic                             c_drop;

  ftc_divider #(
    .DIVIDEND_BITS (W + 1),
    .DIVISOR_BITS  (ftc_pkg::FPS_BITS),
    .STEP_BITS     (STEP_BITS),
    .SIDE_BITS     (1)
  ) u_div_second (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (b_valid),
    .in_dividend   (b_count),
    .in_divisor    (b_rate.fps),
    .in_side       (b_rate.drop),
    .out_valid     (c_valid),
    .out_quotient  (c_total_sec),
    .out_remainder (c_frames),
    .out_side      (c_drop)
  );

  // ---------------------------------------------------------------------
  // Stage D: hours and the second within the hour
  // ---------------------------------------------------------------------
  logic                               d_valid;
  logic [W:0]                         d_hours;
  logic [ftc_pkg::HOUR_REM_BITS-1:0]  d_hour_sec;
  logic [SIDE_C-1:0]                  d_side;

  ftc_divider #(
    .DIVIDEND_BITS (W + 1),
    .DIVISOR_BITS  (ftc_pkg::HOUR_REM_BITS),
    .STEP_BITS     (STEP_BITS),
    .SIDE_BITS     (SIDE_C)
  ) u_div_hour (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (c_valid),
    .in_dividend   (c_total_sec),
    .in_divisor    (ftc_pkg::HOUR_REM_BITS'(ftc_pkg::SECONDS_PER_HOUR)),
    .in_side       ({c_drop, c_frames}),
    .out_valid     (d_valid),
    .out_quotient  (d_hours),
    .out_remainder (d_hour_sec),
    .out_side      (d_side)
  );

  // ---------------------------------------------------------------------
  // Stage E: minutes and seconds; its registers drive the result ports
  // ---------------------------------------------------------------------
  logic [ftc_pkg::HOUR_REM_BITS-1:0]  e_minutes;
  logic [SIDE_D-1:0]                  e_side;
  logic                               out_drop;

  ftc_divider #(
    .DIVIDEND_BITS (ftc_pkg::HOUR_REM_BITS),
    .DIVISOR_BITS  (ftc_pkg::SECONDS_BITS),
    .STEP_BITS     (STEP_BITS),
    .SIDE_BITS     (SIDE_D)
  ) u_div_minute (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (d_valid),
    .in_dividend   (d_hour_sec),
    .in_divisor    (ftc_pkg::SECONDS_BITS'(ftc_pkg::SECONDS_PER_MINUTE)),
    .in_side       ({d_side, d_hours[ftc_pkg::HOURS_BITS-1:0]}),
    .out_valid     (done),
    .out_quotient  (e_minutes),
    .out_remainder (seconds),
    .out_side      (e_side)
  );

  // Hours wrap at 2^21; no wrap at 24
  assign hours    = e_side[ftc_pkg::HOURS_BITS-1:0];
  assign frames   = e_side[ftc_pkg::HOURS_BITS +: ftc_pkg::FRAMES_BITS];
  assign out_drop = e_side[SIDE_D-1];
  assign minutes  = e_minutes[ftc_pkg::MINUTES_BITS-1:0];

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  a_latency_fwd: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LATENCY done)
    else $error("accepted beat did not reach done after the fixed latency");

  a_latency_bwd: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("done without a matching accepted beat");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (e_minutes < 12'(ftc_pkg::SECONDS_PER_MINUTE)) &&
             (seconds < ftc_pkg::SECONDS_BITS'(ftc_pkg::SECONDS_PER_MINUTE)))
    else $error("minutes or seconds out of range");

  a_drop_label: assert property (@(posedge clk) disable iff (rst)
    done && out_drop |-> frames < ftc_pkg::FRAMES_BITS'(ftc_pkg::DF_LABELS))
    else $error("drop-frame label beyond 29");

endmodule
